// File: rtl/core/grid_ray_wall_cast_defines.svh
// Assertion macros shared by the grid ray caster RTL.
// Define NO_ASSERTIONS to compile them out; no other dependencies.
`ifndef GRID_RAY_WALL_CAST_DEFINES_SVH
`define GRID_RAY_WALL_CAST_DEFINES_SVH
`ifndef NO_ASSERTIONS
// Checked property, suspended while reset is high
`define GRC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Checked property, active during reset as well
`define GRC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define GRC_ASSERT(lbl, prop, msg)
`define GRC_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// File: rtl/core/grc_pkg.sv
// Shared types and constants for the grid ray caster.
// No dependencies; used by the controller, datapath and top level.
`default_nettype none
package grc_pkg;

  localparam int MapWidthDef   = 64;
  localparam int MapHeightDef  = 64;
  localparam int TilePixelsDef = 64;

  localparam logic [19:0] Max20  = 20'hFFFFF;
  localparam logic [31:0] InfLen = 32'hFFFFFFFF;
  localparam int          DivSteps = 20;

  typedef struct packed {
    logic               action;
    logic [5:0]         cell_x;
    logic [5:0]         cell_y;
    logic               cell_is_wall;
    logic [19:0]        origin_x;
    logic [19:0]        origin_y;
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_y;
    logic [31:0]        step_len_x;
    logic [31:0]        step_len_y;
  } in_item_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_SX,
    OP_SY,
    OP_IX,
    OP_IY,
    OP_WALK,
    OP_DIV_SETUP,
    OP_DIV_STEP,
    OP_HPX,
    OP_HPY
  } op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SX,
    S_SY,
    S_IX,
    S_IY,
    S_WALK,
    S_DSET,
    S_DIV,
    S_HPX,
    S_HPY,
    S_DONE
  } state_t;

  typedef struct packed {
    op_t  op;
    logic load_out;
    logic out_esc;
  } cmd_t;

  typedef struct packed {
    logic start_out;
    logic walk_end;
    logic walk_esc;
    logic dist_ready;
    logic div_last;
  } status_t;

endpackage
`default_nettype wire

// File: rtl/core/grc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module grc_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/grc_ctrl.sv
// Sequencer for the grid ray caster: accepts beats, steps the datapath.
// Depends on grc_pkg and grid_ray_wall_cast_defines.svh.
`default_nettype none
`include "grid_ray_wall_cast_defines.svh"
module grc_ctrl import grc_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    s_tvalid,
  input  wire logic    s_action,
  output logic         s_tready,
  output logic         m_tvalid,
  input  wire logic    m_tready,
  output cmd_t         cmd,
  input  wire status_t status
);

  state_t state, state_next;
  logic   esc, esc_next;
  logic   m_tvalid_next;

  // State, escape flag and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      esc      <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      state    <= state_next;
      esc      <= esc_next;
      m_tvalid <= m_tvalid_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next   = state;
    esc_next     = esc;
    s_tready     = 1'b0;
    cmd.op       = OP_NONE;
    cmd.load_out = 1'b0;
    cmd.out_esc  = esc;
    case (state)
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.op   = OP_LOAD;
          esc_next = 1'b0;
          if (s_action) begin
            state_next = S_SX;
          end
        end
      end
      S_SX: begin
        if (status.start_out) begin
          esc_next   = 1'b1;
          state_next = S_DONE;
        end else begin
          cmd.op     = OP_SX;
          state_next = S_SY;
        end
      end
      S_SY: begin
        cmd.op     = OP_SY;
        state_next = S_IX;
      end
      S_IX: begin
        cmd.op     = OP_IX;
        state_next = S_IY;
      end
      S_IY: begin
        cmd.op     = OP_IY;
        state_next = S_WALK;
      end
      S_WALK: begin
        cmd.op = OP_WALK;
        if (status.walk_end) begin
          esc_next   = status.walk_esc;
          state_next = status.walk_esc ? S_DONE : S_DSET;
        end
      end
      S_DSET: begin
        cmd.op     = OP_DIV_SETUP;
        state_next = status.dist_ready ? S_HPX : S_DIV;
      end
      S_DIV: begin
        cmd.op = OP_DIV_STEP;
        if (status.div_last) begin
          state_next = S_HPX;
        end
      end
      S_HPX: begin
        cmd.op     = OP_HPX;
        state_next = S_HPY;
      end
      S_HPY: begin
        cmd.op     = OP_HPY;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (!m_tvalid || m_tready) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Output valid: set on load, drop when taken
  always_comb begin
    m_tvalid_next = m_tvalid;
    if (cmd.load_out) begin
      m_tvalid_next = 1'b1;
    end else if (m_tready) begin
      m_tvalid_next = 1'b0;
    end
  end

  `GRC_ASSERT(a_load_free, cmd.load_out |-> (!m_tvalid || m_tready), "result overwritten")
  `GRC_ASSERT(a_load_valid, cmd.load_out |=> m_tvalid, "loaded result not shown")
  `GRC_ASSERT(a_cast_busy, (s_tvalid && s_tready && s_action) |=> !s_tready, "cast not held")
  `GRC_ASSERT_ALWAYS(a_rst_idle, $past(rst) |-> (state == S_IDLE && !m_tvalid), "bad reset")

endmodule
`default_nettype wire

// File: rtl/core/grc_dp.sv
// Datapath of the grid ray caster: wall map, side distances, cell walk,
// serial divider and hit-point multiply. Depends on grc_pkg and grc_ram.
`default_nettype none
module grc_dp import grc_pkg::*; #(
  parameter int MAP_WIDTH   = MapWidthDef,
  parameter int MAP_HEIGHT  = MapHeightDef,
  parameter int TILE_PIXELS = TilePixelsDef
) (
  input  wire logic     clk,
  input  wire in_item_t in_item,
  input  wire cmd_t     cmd,
  output status_t       status,
  output logic [19:0]   distance,
  output logic          hit_side,
  output logic [5:0]    hit_cell_x,
  output logic [5:0]    hit_cell_y,
  output logic [19:0]   hit_point_x,
  output logic [19:0]   hit_point_y,
  output logic          escaped
);

  localparam int CellQ8 = TILE_PIXELS * 256;
  localparam int CQW    = $clog2(CellQ8 + 1);
  localparam int XW     = $clog2(MAP_WIDTH) + 1;
  localparam int YW     = $clog2(MAP_HEIGHT) + 1;
  localparam int CW     = (XW > YW) ? XW : YW;
  localparam int OFFW   = (7 + CQW > 21) ? 7 + CQW : 21;
  localparam int PXW    = (CW + CQW > 22) ? CW + CQW : 22;
  localparam int Depth  = MAP_WIDTH * MAP_HEIGHT;
  localparam int AW     = $clog2(Depth);
  localparam int PW     = OFFW + 32;

  in_item_t          it;
  logic [XW-1:0]     cx, nx;
  logic [YW-1:0]     cy, ny;
  logic [63:0]       sx, sy, ix, iy;
  logic              side, pend;
  logic [19:0]       dist_q;
  logic [16:0]       rem;
  logic [19:0]       nsh;
  logic [4:0]        cnt;
  logic [15:0]       dabs, dabs_x, dabs_y;
  logic [19:0]       hpx, hpy;

  logic              neg_x, neg_y;
  logic [OFFW-1:0]   offx, offy, lo_x, hi_x, lo_y, hi_y;
  logic [OFFW-1:0]   mul_a;
  logic [31:0]       mul_b;
  logic [PW-1:0]     mul_p;
  logic [64:0]       sum_x, sum_y;
  logic              take_x, hit_now, out_now, rdata, we;
  logic [AW-1:0]     waddr, raddr;

  logic              dneg;
  logic [PXW-1:0]    cellpix, ori, mag;
  logic              off_neg, off_zero, sat;
  logic [16:0]       trial;
  logic [20:0]       qh;
  logic [21:0]       hsum;
  logic [19:0]       horg, hres;
  logic              hneg;

  assign neg_x  = it.dir_x[15];
  assign neg_y  = it.dir_y[15];
  assign dabs_x = neg_x ? 16'(-it.dir_x) : 16'(it.dir_x);
  assign dabs_y = neg_y ? 16'(-it.dir_y) : 16'(it.dir_y);

  // Wall map
  assign we    = (cmd.op == OP_LOAD) && !in_item.action &&
                 (32'(in_item.cell_x) < MAP_WIDTH) && (32'(in_item.cell_y) < MAP_HEIGHT);
  assign waddr = AW'(32'(in_item.cell_y) * MAP_WIDTH + 32'(in_item.cell_x));

  grc_ram #(.WIDTH(1), .DEPTH(Depth)) u_map (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (in_item.cell_is_wall),
    .re    ((cmd.op == OP_WALK) && !hit_now && !out_now),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Initial pixel offsets to the first cell boundary, clamped at zero
  always_comb begin
    lo_x = OFFW'(it.cell_x) * OFFW'(CellQ8);
    hi_x = OFFW'({1'b0, it.cell_x} + 7'd1) * OFFW'(CellQ8);
    lo_y = OFFW'(it.cell_y) * OFFW'(CellQ8);
    hi_y = OFFW'({1'b0, it.cell_y} + 7'd1) * OFFW'(CellQ8);
    if (neg_x) begin
      offx = (OFFW'(it.origin_x) > lo_x) ? OFFW'(it.origin_x) - lo_x : '0;
    end else begin
      offx = (hi_x > OFFW'(it.origin_x)) ? hi_x - OFFW'(it.origin_x) : '0;
    end
    if (neg_y) begin
      offy = (OFFW'(it.origin_y) > lo_y) ? OFFW'(it.origin_y) - lo_y : '0;
    end else begin
      offy = (hi_y > OFFW'(it.origin_y)) ? hi_y - OFFW'(it.origin_y) : '0;
    end
  end

  // Shared multiplier operand select
  always_comb begin
    mul_a = OFFW'(CellQ8);
    mul_b = it.step_len_x;
    case (cmd.op)
      OP_SX: begin
        mul_a = offx;
      end
      OP_SY: begin
        mul_a = offy;
        mul_b = it.step_len_y;
      end
      OP_IY: begin
        mul_b = it.step_len_y;
      end
      OP_HPX: begin
        mul_a = OFFW'(dabs_x);
        mul_b = 32'(dist_q);
      end
      OP_HPY: begin
        mul_a = OFFW'(dabs_y);
        mul_b = 32'(dist_q);
      end
      default: ;
    endcase
    mul_p = PW'(mul_a) * PW'(mul_b);
  end

  // One cell step: pick the nearer side, move, check the map bounds
  always_comb begin
    hit_now = pend && rdata;
    take_x  = sx < sy;
    sum_x   = {1'b0, sx} + {1'b0, ix};
    sum_y   = {1'b0, sy} + {1'b0, iy};
    nx      = cx;
    ny      = cy;
    if (take_x) begin
      nx = neg_x ? cx - XW'(1) : cx + XW'(1);
    end else begin
      ny = neg_y ? cy - YW'(1) : cy + YW'(1);
    end
    out_now = (32'(nx) >= MAP_WIDTH) || (32'(ny) >= MAP_HEIGHT);
    raddr   = AW'(32'(ny) * MAP_WIDTH + 32'(nx));
  end

  // Offset from origin to the hit wall plane, and divider step
  always_comb begin
    dneg     = side ? neg_y : neg_x;
    dabs     = side ? dabs_y : dabs_x;
    ori      = side ? PXW'(it.origin_y) : PXW'(it.origin_x);
    cellpix  = side ? (PXW'(cy) + PXW'(dneg)) * PXW'(CellQ8)
                    : (PXW'(cx) + PXW'(dneg)) * PXW'(CellQ8);
    off_neg  = ori > cellpix;
    off_zero = ori == cellpix;
    mag      = off_neg ? ori - cellpix : cellpix - ori;
    sat      = mag >= PXW'({dabs, 6'b0});
    trial    = {rem[15:0], nsh[19]};
  end

  // Hit point from origin plus direction times distance, clamped
  always_comb begin
    qh   = mul_p[34:14];
    hneg = (cmd.op == OP_HPY) ? neg_y : neg_x;
    horg = (cmd.op == OP_HPY) ? it.origin_y : it.origin_x;
    hsum = {1'b0, qh} + 22'(horg);
    if (hneg) begin
      hres = (qh > 21'(horg)) ? '0 : 20'(21'(horg) - qh);
    end else begin
      hres = (hsum > 22'(Max20)) ? Max20 : hsum[19:0];
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        it <= in_item;
        cx <= XW'(in_item.cell_x);
        cy <= YW'(in_item.cell_y);
      end
      OP_SX: sx <= (it.step_len_x == InfLen) ? '1 : 64'(mul_p);
      OP_SY: sy <= (it.step_len_y == InfLen) ? '1 : 64'(mul_p);
      OP_IX: ix <= (it.step_len_x == InfLen) ? '1 : 64'(mul_p);
      OP_IY: begin
        iy   <= (it.step_len_y == InfLen) ? '1 : 64'(mul_p);
        pend <= 1'b0;
      end
      OP_WALK: begin
        if (!hit_now) begin
          pend <= 1'b1;
          cx   <= nx;
          cy   <= ny;
          side <= !take_x;
          if (take_x) begin
            sx <= sum_x[64] ? '1 : sum_x[63:0];
          end else begin
            sy <= sum_y[64] ? '1 : sum_y[63:0];
          end
        end
      end
      OP_DIV_SETUP: begin
        rem  <= 17'(mag >> 6);
        nsh  <= {mag[5:0], 14'b0};
        cnt  <= '0;
        if (dabs == '0) begin
          dist_q <= Max20;
        end else if (off_zero || (off_neg != dneg)) begin
          dist_q <= '0;
        end else if (sat) begin
          dist_q <= Max20;
        end else begin
          dist_q <= '0;
        end
      end
      OP_DIV_STEP: begin
        nsh <= {nsh[18:0], 1'b0};
        cnt <= cnt + 5'd1;
        if (trial >= 17'(dabs)) begin
          rem    <= trial - 17'(dabs);
          dist_q <= {dist_q[18:0], 1'b1};
        end else begin
          rem    <= trial;
          dist_q <= {dist_q[18:0], 1'b0};
        end
      end
      OP_HPX: hpx <= hres;
      OP_HPY: hpy <= hres;
      default: ;
    endcase
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      escaped     <= cmd.out_esc;
      distance    <= cmd.out_esc ? '0 : dist_q;
      hit_side    <= cmd.out_esc ? 1'b0 : side;
      hit_cell_x  <= cmd.out_esc ? '0 : 6'(cx);
      hit_cell_y  <= cmd.out_esc ? '0 : 6'(cy);
      hit_point_x <= cmd.out_esc ? '0 : hpx;
      hit_point_y <= cmd.out_esc ? '0 : hpy;
    end
  end

  // Status to the sequencer
  always_comb begin
    status.start_out  = (32'(it.cell_x) >= MAP_WIDTH) || (32'(it.cell_y) >= MAP_HEIGHT);
    status.walk_end   = hit_now || out_now;
    status.walk_esc   = !hit_now && out_now;
    status.dist_ready = (dabs == '0) || off_zero || (off_neg != dneg) || sat;
    status.div_last   = cnt == 5'(DivSteps - 1);
  end

endmodule
`default_nettype wire

// File: rtl/core/grid_ray_wall_cast.sv
// Channel  Dir  Beat contents
// s_*      in   tuser: action; tdata: map write or cast request
// m_*      out  tuser: escaped; tdata: one result per cast
// A cast loads its beat, runs the x and y side-distance and step setup,
// walks one cell step per cycle (at most MAP_WIDTH + MAP_HEIGHT, set by the
// map bounds) until a wall is seen, then runs the divider setup and serial
// divide (skipped for a zero or saturated distance), the hit-point multiplies
// and the load; an escaped ray goes straight to the load. A new beat is taken
// once the previous cast is in the result register; a stalled result holds.
// Reset is synchronous; the map is not cleared.
// Depends on grc_pkg, grc_ctrl, grc_dp.
`default_nettype none
module grid_ray_wall_cast import grc_pkg::*; #(
  parameter int MAP_WIDTH   = MapWidthDef,
  parameter int MAP_HEIGHT  = MapHeightDef,
  parameter int TILE_PIXELS = TilePixelsDef
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  // cell_x, cell_y, cell_is_wall, origin_x, origin_y, dir_x, dir_y,
  // step_len_x, step_len_y, zero pad
  input  wire logic [151:0] s_tdata,
  // action
  input  wire logic         s_tuser,
  output logic              m_tvalid,
  input  wire logic         m_tready,
  // distance, hit_side, hit_cell_x, hit_cell_y, hit_point_x, hit_point_y, zero pad
  output logic [79:0]       m_tdata,
  // escaped
  output logic              m_tuser
);

  in_item_t    item;
  cmd_t        cmd;
  status_t     status;
  logic [19:0] distance, hit_point_x, hit_point_y;
  logic [5:0]  hit_cell_x, hit_cell_y;
  logic        hit_side;

  // Unpack the request beat
  always_comb begin
    item.action       = s_tuser;
    item.cell_x       = s_tdata[5:0];
    item.cell_y       = s_tdata[11:6];
    item.cell_is_wall = s_tdata[12];
    item.origin_x     = s_tdata[32:13];
    item.origin_y     = s_tdata[52:33];
    item.dir_x        = s_tdata[68:53];
    item.dir_y        = s_tdata[84:69];
    item.step_len_x   = s_tdata[116:85];
    item.step_len_y   = s_tdata[148:117];
  end

  grc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_action (s_tuser),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd),
    .status   (status)
  );

  grc_dp #(
    .MAP_WIDTH   (MAP_WIDTH),
    .MAP_HEIGHT  (MAP_HEIGHT),
    .TILE_PIXELS (TILE_PIXELS)
  ) u_dp (
    .clk         (clk),
    .in_item     (item),
    .cmd         (cmd),
    .status      (status),
    .distance    (distance),
    .hit_side    (hit_side),
    .hit_cell_x  (hit_cell_x),
    .hit_cell_y  (hit_cell_y),
    .hit_point_x (hit_point_x),
    .hit_point_y (hit_point_y),
    .escaped     (m_tuser)
  );

  // Pack the result beat
  assign m_tdata = {7'b0, hit_point_y, hit_point_x, hit_cell_y, hit_cell_x, hit_side, distance};

endmodule
`default_nettype wire

// File: tb/grid_ray_wall_cast_tb.sv
// Self-checking bench for grid_ray_wall_cast: map writes and DDA ray casts.
// Predicts each cast result in-bench; depends on grc_pkg and the RTL only.
`default_nettype none
module grid_ray_wall_cast_tb;
  import grc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MapW = 64;
  localparam int MapH = 64;
  localparam int Region = 16;
  localparam longint CellQ8 = 64 * 256;
  localparam bit ActWrite = 1'b0;
  localparam bit ActCast  = 1'b1;

  typedef struct packed {
    logic [19:0] distance;
    logic        hit_side;
    logic [5:0]  hit_cell_x;
    logic [5:0]  hit_cell_y;
    logic [19:0] hit_point_x;
    logic [19:0] hit_point_y;
    logic        escaped;
  } cast_res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [151:0] s_tdata = '0;
  logic s_tuser = 1'b0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [79:0] m_tdata;
  logic m_tuser;

  grid_ray_wall_cast dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  in_item_t  pending_beats[$];
  cast_res_t expected_hits[$];
  bit        wall_bits[MapW*MapH];
  int        send_idle_pct = 31;
  int        recv_idle_pct = 71;
  int        mismatches = 0;

  // Side distance to the first grid line on one axis.
  function automatic longint unsigned first_side(longint org, longint cell_idx,
                                                 int dir, longint unsigned len);
    longint off;
    if (len == 64'hFFFFFFFF) return '1;
    off = (dir < 0) ? org - cell_idx * CellQ8 : (cell_idx + 1) * CellQ8 - org;
    if (off < 0) off = 0;
    return longint'(off) * len;
  endfunction

  function automatic longint unsigned sat_sum(longint unsigned a, longint unsigned b);
    return (a > 64'hFFFFFFFFFFFFFFFF - b) ? '1 : a + b;
  endfunction

  function automatic longint unsigned perp_q8(longint off, int dir);
    longint unsigned q, mag;
    if (dir == 0) return 20'hFFFFF;
    if (off == 0 || ((off < 0) != (dir < 0))) return 0;
    mag = (off < 0) ? -off : off;
    q = (mag << 14) / longint'(dir < 0 ? -dir : dir);
    return (q > 20'hFFFFF) ? 20'hFFFFF : q;
  endfunction

  function automatic logic [19:0] landing(longint unsigned org, int dir,
                                          longint unsigned dist_q8);
    longint unsigned q;
    q = (longint'(dir < 0 ? -dir : dir) * dist_q8) >> 14;
    if (dir < 0) return (q > org) ? 20'd0 : 20'(org - q);
    q += org;
    return (q > 20'hFFFFF) ? 20'hFFFFF : 20'(q);
  endfunction

  // Walk the grid from the start cell until a wall or the map edge.
  function automatic cast_res_t trace_ray(in_item_t it);
    cast_res_t r;
    longint cx, cy, stx, sty, off;
    longint unsigned sx, sy, ix, iy, dist_q8;
    int dx, dy;
    bit side;
    r = '0;
    cx = it.cell_x; cy = it.cell_y;
    dx = it.dir_x; dy = it.dir_y;
    stx = (dx < 0) ? -1 : 1;
    sty = (dy < 0) ? -1 : 1;
    sx = first_side(it.origin_x, cx, dx, it.step_len_x);
    sy = first_side(it.origin_y, cy, dy, it.step_len_y);
    ix = (it.step_len_x == 32'hFFFFFFFF) ? '1 : CellQ8 * it.step_len_x;
    iy = (it.step_len_y == 32'hFFFFFFFF) ? '1 : CellQ8 * it.step_len_y;
    side = 0;
    forever begin
      if (sx < sy) begin
        sx = sat_sum(sx, ix); cx += stx; side = 0;
      end else begin
        sy = sat_sum(sy, iy); cy += sty; side = 1;
      end
      if (cx < 0 || cx >= MapW || cy < 0 || cy >= MapH) begin
        r.escaped = 1'b1;
        return r;
      end
      if (wall_bits[cy*MapW + cx]) break;
    end
    if (!side) begin
      off = cx * CellQ8 - longint'(it.origin_x) + ((stx < 0) ? CellQ8 : 0);
      dist_q8 = perp_q8(off, dx);
    end else begin
      off = cy * CellQ8 - longint'(it.origin_y) + ((sty < 0) ? CellQ8 : 0);
      dist_q8 = perp_q8(off, dy);
    end
    r.distance = 20'(dist_q8);
    r.hit_side = side;
    r.hit_cell_x = 6'(cx);
    r.hit_cell_y = 6'(cy);
    r.hit_point_x = landing(it.origin_x, dx, dist_q8);
    r.hit_point_y = landing(it.origin_y, dy, dist_q8);
    return r;
  endfunction

  function automatic logic [151:0] pack_beat(in_item_t it);
    return {3'd0, it.step_len_y, it.step_len_x, it.dir_y, it.dir_x, it.origin_y,
            it.origin_x, it.cell_is_wall, it.cell_y, it.cell_x};
  endfunction

  // Driver: present queued beats, idle at random, predict on acceptance.
  always @(posedge clk) begin
    in_item_t it;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        it = pending_beats.pop_front();
        if (it.action == ActWrite) wall_bits[{it.cell_y, it.cell_x}] = it.cell_is_wall;
        else expected_hits.push_back(trace_ray(it));
      end
      if ((!s_tvalid || s_tready) && pending_beats.size() > 0 &&
          $urandom_range(99) >= send_idle_pct) begin
        s_tvalid <= 1'b1;
        s_tdata  <= pack_beat(pending_beats[0]);
        s_tuser  <= pending_beats[0].action;
      end else if (!s_tvalid || s_tready) begin
        s_tvalid <= 1'b0;
      end
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Monitor: compare each result beat with the oldest prediction.
  always @(posedge clk) begin
    cast_res_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got = {m_tdata[19:0], m_tdata[20], m_tdata[26:21], m_tdata[32:27],
             m_tdata[52:33], m_tdata[72:53], m_tuser};
      if (expected_hits.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat %h", got);
      end else begin
        want = expected_hits.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result mismatch: expected %h got %h", want, got);
        end
      end
    end
  end

  function automatic in_item_t rand_write(int x, int y, bit w);
    in_item_t it;
    it = '0;
    it.action = ActWrite; it.cell_x = 6'(x); it.cell_y = 6'(y); it.cell_is_wall = w;
    it.origin_x = 20'($urandom); it.origin_y = 20'($urandom);
    it.dir_x = 16'($urandom); it.dir_y = 16'($urandom);
    it.step_len_x = $urandom; it.step_len_y = $urandom;
    return it;
  endfunction

  // Random cast from inside the fenced corner: origin mostly inside the start
  // cell, steps near |1/dir|.
  function automatic in_item_t rand_cast();
    in_item_t it;
    int ax, ay;
    it = '0;
    it.action = ActCast;
    it.cell_x = 6'($urandom_range(Region - 2)); it.cell_y = 6'($urandom_range(Region - 2));
    it.cell_is_wall = 1'($urandom);
    if ($urandom_range(9) == 0) begin
      it.origin_x = 20'($urandom); it.origin_y = 20'($urandom);
    end else begin
      it.origin_x = 20'(it.cell_x * CellQ8 + $urandom_range(CellQ8 - 1));
      it.origin_y = 20'(it.cell_y * CellQ8 + $urandom_range(CellQ8 - 1));
    end
    case ($urandom_range(7))
      0: begin it.dir_x = 16'($urandom); it.dir_y = 16'($urandom); end
      1: begin it.dir_x = 0; it.dir_y = $urandom_range(1) ? 16384 : -16384; end
      2: begin it.dir_y = 0; it.dir_x = $urandom_range(1) ? 16384 : -16384; end
      default: begin
        it.dir_x = 16'($urandom_range(32768) - 16384);
        it.dir_y = 16'($urandom_range(32768) - 16384);
      end
    endcase
    ax = it.dir_x < 0 ? -it.dir_x : it.dir_x;
    ay = it.dir_y < 0 ? -it.dir_y : it.dir_y;
    it.step_len_x = (ax == 0 || $urandom_range(19) == 0) ? 32'hFFFFFFFF :
                    32'((64'd1 << 30) / ax);
    it.step_len_y = (ay == 0 || $urandom_range(19) == 0) ? 32'hFFFFFFFF :
                    32'((64'd1 << 30) / ay);
    if ($urandom_range(19) == 0) it.step_len_x = $urandom;
    if ($urandom_range(19) == 0) it.step_len_y = $urandom;
    return it;
  endfunction

  initial begin
    in_item_t it;
    int phase_len;
    // Map a corner fenced by walls on its far row and column; random casts
    // start inside it, so every cell a cast reads has been written.
    for (int y = 0; y < Region; y++)
      for (int x = 0; x < Region; x++)
        pending_beats.push_back(rand_write(x, y, (x == Region - 1) || (y == Region - 1) ||
                                                 ($urandom_range(9) < 2)));
    // Directed: axis-aligned, zero direction, infinite steps, edges, bad origin.
    pending_beats.push_back(rand_write(10, 10, 1));
    pending_beats.push_back(rand_write(14, 10, 1));
    it = rand_cast();
    it.cell_x = 10; it.cell_y = 10; it.origin_x = 10*CellQ8 + 100;
    it.origin_y = 10*CellQ8 + 100; it.dir_x = 16384; it.dir_y = 0;
    it.step_len_x = 32'h10000; it.step_len_y = 32'hFFFFFFFF;
    pending_beats.push_back(it);
    it.dir_x = -16384; it.dir_y = 0; pending_beats.push_back(it);
    it.dir_x = 0; it.dir_y = 16384; it.step_len_x = 32'hFFFFFFFF;
    it.step_len_y = 32'h10000; pending_beats.push_back(it);
    it.dir_y = -16384; pending_beats.push_back(it);
    it.dir_x = 16'h8000; it.dir_y = 16'h7FFF; it.step_len_x = 0; it.step_len_y = 0;
    pending_beats.push_back(it);
    it.cell_x = 63; it.cell_y = 63; it.origin_x = 20'hFFFFF; it.origin_y = 20'hFFFFF;
    it.dir_x = 16384; it.dir_y = 16384; it.step_len_x = 32'h10000;
    it.step_len_y = 32'h10000; pending_beats.push_back(it);
    it.cell_x = 0; it.cell_y = 0; it.origin_x = 0; it.origin_y = 0;
    it.dir_x = -16384; it.dir_y = -16384; pending_beats.push_back(it);
    it.cell_x = 5; it.cell_y = 5; it.origin_x = 40*CellQ8; it.origin_y = 0;
    it.dir_x = 11585; it.dir_y = -11585; it.step_len_x = 32'h16A09;
    it.step_len_y = 32'hFFFFFFFE; pending_beats.push_back(it);
    it.dir_x = 0; it.dir_y = 0; it.step_len_x = 32'h10000; it.step_len_y = 32'h20000;
    pending_beats.push_back(it);
    it.dir_x = 16384; it.step_len_x = 32'hFFFFFFFF; it.step_len_y = 32'hFFFFFFFF;
    pending_beats.push_back(it);
    // Random: mostly casts with some map rewrites, split over three idle phases.
    phase_len = 500;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    for (int ph = 0; ph < 3; ph++) begin
      if (ph == 1) begin send_idle_pct = 71; recv_idle_pct = 31; end
      if (ph == 2) begin send_idle_pct = 0;  recv_idle_pct = 0;  end
      for (int i = 0; i < phase_len; i++)
        if ($urandom_range(3) == 0)
          pending_beats.push_back(rand_write($urandom_range(Region - 2),
                                             $urandom_range(Region - 2),
                                             ($urandom_range(9) < 3)));
        else
          pending_beats.push_back(rand_cast());
      while (pending_beats.size() > 0 || s_tvalid) @(posedge clk);
    end
    while (expected_hits.size() > 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (mismatches == 0 && expected_hits.size() == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

  initial begin
    #20ms;
    $display("tb: failure");
    $finish;
  end
endmodule
`default_nettype wire
